[rtl/mwsm_pkg.sv]
package mwsm_pkg;

   // Field widths
   localparam int CMD_W   = 16;   // command input fields
   localparam int LIM_W   = 10;   // command clamp limits
   localparam int WLIM_W  = 12;   // wheel limit
   localparam int CLAMP_W = LIM_W + 1;    // clamped command, signed
   localparam int WHEEL_W = 13;   // wheel speed, signed
   localparam int MAG_W   = 12;   // wheel magnitude
   localparam int NUM_W   = MAG_W + WLIM_W;   // magnitude * wheel limit
   localparam int QUO_W   = WLIM_W;   // quotient never exceeds the wheel limit
   localparam int NWHEEL  = 4;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LAYOUT      = 3'd0,
      REG_VX_LIMIT    = 3'd1,
      REG_VY_LIMIT    = 3'd2,
      REG_OMEGA_LIMIT = 3'd3,
      REG_WHEEL_LIMIT = 3'd4
   } reg_index_type;

   localparam logic [LIM_W-1:0]  VX_LIMIT_RESET    = 10'd660;
   localparam logic [LIM_W-1:0]  VY_LIMIT_RESET    = 10'd660;
   localparam logic [LIM_W-1:0]  OMEGA_LIMIT_RESET = 10'd300;
   localparam logic [WLIM_W-1:0] WHEEL_LIMIT_RESET = 12'd1000;

   // Pipeline shape
   localparam int MIX_STAGES                 = 4;
   localparam int DIV_BITS_PER_STAGE_DEFAULT = 2;

   typedef struct packed {
      logic              layout;
      logic [LIM_W-1:0]  vx_lim;
      logic [LIM_W-1:0]  vy_lim;
      logic [LIM_W-1:0]  om_lim;
      logic [WLIM_W-1:0] wheel_lim;
   } cfg_type;

   // Sideband that rides along the divider stages
   typedef struct packed {
      logic                            scaled;
      logic [MAG_W-1:0]                top;
      logic [NWHEEL-1:0][WHEEL_W-1:0]  wheel;
   } side_type;

   // Per lane {remainder, dividend low bits / quotient bits}
   typedef struct packed {
      logic [NWHEEL-1:0][NUM_W-1:0] work;
   } div_type;

   // Symmetric clamp of a signed command to +/- lim
   function automatic logic signed [CLAMP_W-1:0] clamp_sym(
      input logic signed [CMD_W-1:0] v,
      input logic [LIM_W-1:0]        lim
   );
      logic signed [CMD_W:0] ext;
      logic signed [CMD_W:0] hi;
      logic signed [CMD_W:0] lo;
      logic signed [CMD_W:0] res;
      ext = {v[CMD_W-1], v};
      hi  = $signed({{(CMD_W + 1 - LIM_W){1'b0}}, lim});
      lo  = -hi;
      if (ext > hi) begin
         res = hi;
      end else if (ext < lo) begin
         res = lo;
      end else begin
         res = ext;
      end
      return res[CLAMP_W-1:0];
   endfunction

   // Magnitude of a wheel speed
   function automatic logic [MAG_W-1:0] wheel_mag(input logic [WHEEL_W-1:0] w);
      logic [WHEEL_W-1:0] a;
      a = w[WHEEL_W-1] ? (~w + 1'b1) : w;
      return a[MAG_W-1:0];
   endfunction

endpackage

[rtl/mwsm_req_if.sv]
interface mwsm_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [mwsm_pkg::CMD_W-1:0]  cmd_vx;
   logic signed [mwsm_pkg::CMD_W-1:0]  cmd_vy;
   logic signed [mwsm_pkg::CMD_W-1:0]  cmd_omega;

   modport source(output valid, output cmd_vx, output cmd_vy, output cmd_omega,
                  input ready);
   modport sink(input valid, input cmd_vx, input cmd_vy, input cmd_omega,
                output ready);
endinterface

[rtl/mwsm_rsp_if.sv]
interface mwsm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mwsm_pkg::WHEEL_W-1:0] wheel_a_speed;
   logic signed [mwsm_pkg::WHEEL_W-1:0] wheel_b_speed;
   logic signed [mwsm_pkg::WHEEL_W-1:0] wheel_c_speed;
   logic signed [mwsm_pkg::WHEEL_W-1:0] wheel_d_speed;
   logic                                was_scaled;

   modport source(output valid, output wheel_a_speed, output wheel_b_speed,
                  output wheel_c_speed, output wheel_d_speed, output was_scaled,
                  input ready);
   modport sink(input valid, input wheel_a_speed, input wheel_b_speed,
                input wheel_c_speed, input wheel_d_speed, input was_scaled,
                output ready);
endinterface

[rtl/mwsm_csr_if.sv]
interface mwsm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mwsm_pkg::CSR_IDX_W-1:0]      index;
   logic [mwsm_pkg::CSR_DATA_W-1:0]     data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

[rtl/mwsm_csr.sv]
module mwsm_csr (
   input  logic                clock,
   input  logic                reset,
   mwsm_csr_if.sink            csr_bus,
   output mwsm_pkg::cfg_type   cfg
);

   mwsm_pkg::cfg_type cfg_ff;
   mwsm_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            mwsm_pkg::REG_LAYOUT:      cfg_in.layout    = csr_bus.data[0];
            mwsm_pkg::REG_VX_LIMIT:    cfg_in.vx_lim    = csr_bus.data[mwsm_pkg::LIM_W-1:0];
            mwsm_pkg::REG_VY_LIMIT:    cfg_in.vy_lim    = csr_bus.data[mwsm_pkg::LIM_W-1:0];
            mwsm_pkg::REG_OMEGA_LIMIT: cfg_in.om_lim    = csr_bus.data[mwsm_pkg::LIM_W-1:0];
            mwsm_pkg::REG_WHEEL_LIMIT: cfg_in.wheel_lim = csr_bus.data[mwsm_pkg::WLIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layout    <= 1'b0;
         cfg_ff.vx_lim    <= mwsm_pkg::VX_LIMIT_RESET;
         cfg_ff.vy_lim    <= mwsm_pkg::VY_LIMIT_RESET;
         cfg_ff.om_lim    <= mwsm_pkg::OMEGA_LIMIT_RESET;
         cfg_ff.wheel_lim <= mwsm_pkg::WHEEL_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/mwsm_pipe_ctrl.sv]
module mwsm_pipe_ctrl #(
   parameter int NSTAGE = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              out_ready,
   output logic              in_ready,
   output logic [NSTAGE-1:0] en,
   output logic [NSTAGE-1:0] valid
);

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;

   // A stage loads when it or any stage after it holds a bubble,
   // or when the output beat is taken
   always_comb begin
      for (int i = 0; i < NSTAGE; i++) begin
         en[i] = out_ready || !(&(valid_ff | NSTAGE'((1 << i) - 1)));
      end
   end

   always_comb begin
      valid_in[0] = en[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < NSTAGE; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready = en[0];
   assign valid    = valid_ff;

   // A waiting result is never dropped
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NSTAGE-1] && !out_ready |=> valid_ff[NSTAGE-1])
      else $error("output beat lost while stalled");

   // Input stalls only when every stage is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (&valid_ff) && !out_ready)
      else $error("input stalled with a bubble in the pipe");

endmodule

[rtl/mwsm_mix.sv]
module mwsm_mix (
   input  logic                                   clock,
   input  logic [mwsm_pkg::MIX_STAGES-1:0]        en,
   input  mwsm_pkg::cfg_type                      cfg,
   input  logic signed [mwsm_pkg::CMD_W-1:0]      cmd_vx,
   input  logic signed [mwsm_pkg::CMD_W-1:0]      cmd_vy,
   input  logic signed [mwsm_pkg::CMD_W-1:0]      cmd_omega,
   output mwsm_pkg::side_type                     side,
   output mwsm_pkg::div_type                      work
);

   localparam int NW = mwsm_pkg::NWHEEL;

   // Stage 0: clamp
   logic signed [mwsm_pkg::CLAMP_W-1:0] x_ff, y_ff, w_ff;
   logic signed [mwsm_pkg::CLAMP_W-1:0] x_in, y_in, w_in;

   assign x_in = mwsm_pkg::clamp_sym(cmd_vx, cfg.vx_lim);
   assign y_in = mwsm_pkg::clamp_sym(cmd_vy, cfg.vy_lim);
   assign w_in = mwsm_pkg::clamp_sym(cmd_omega, cfg.om_lim);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff <= x_in;
         y_ff <= y_in;
         w_ff <= w_in;
      end
   end

   // Stage 1: mix into wheels and take magnitudes
   logic signed [mwsm_pkg::WHEEL_W-1:0] xs, ys, ws;
   logic [mwsm_pkg::WHEEL_W-1:0] wheel1_ff [NW];
   logic [mwsm_pkg::WHEEL_W-1:0] wheel1_in [NW];
   logic [mwsm_pkg::MAG_W-1:0]   mag1_ff   [NW];
   logic [mwsm_pkg::MAG_W-1:0]   mag1_in   [NW];

   assign xs = mwsm_pkg::WHEEL_W'(x_ff);
   assign ys = mwsm_pkg::WHEEL_W'(y_ff);
   assign ws = mwsm_pkg::WHEEL_W'(w_ff);

   always_comb begin
      if (cfg.layout) begin
         wheel1_in[0] = xs - ys + ws;
         wheel1_in[1] = -xs - ys + ws;
      end else begin
         wheel1_in[0] = -xs - ys + ws;
         wheel1_in[1] = xs - ys + ws;
      end
      wheel1_in[2] = -xs + ys + ws;
      wheel1_in[3] = xs + ys + ws;
      for (int i = 0; i < NW; i++) begin
         mag1_in[i] = mwsm_pkg::wheel_mag(wheel1_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         wheel1_ff <= wheel1_in;
         mag1_ff   <= mag1_in;
      end
   end

   // Stage 2: largest magnitude and the scale decision
   logic [mwsm_pkg::MAG_W-1:0]   m01, m23;
   logic [mwsm_pkg::MAG_W-1:0]   top2_ff, top2_in;
   logic                         scaled2_ff, scaled2_in;
   logic [mwsm_pkg::WHEEL_W-1:0] wheel2_ff [NW];
   logic [mwsm_pkg::MAG_W-1:0]   mag2_ff   [NW];

   assign m01        = (mag1_ff[0] > mag1_ff[1]) ? mag1_ff[0] : mag1_ff[1];
   assign m23        = (mag1_ff[2] > mag1_ff[3]) ? mag1_ff[2] : mag1_ff[3];
   assign top2_in    = (m01 > m23) ? m01 : m23;
   assign scaled2_in = top2_in > cfg.wheel_lim;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         top2_ff    <= top2_in;
         scaled2_ff <= scaled2_in;
         wheel2_ff  <= wheel1_ff;
         mag2_ff    <= mag1_ff;
      end
   end

   // Stage 3: dividend = magnitude * wheel limit
   mwsm_pkg::side_type side3_ff, side3_in;
   mwsm_pkg::div_type  work3_ff, work3_in;

   always_comb begin
      side3_in.scaled = scaled2_ff;
      side3_in.top    = top2_ff;
      for (int i = 0; i < NW; i++) begin
         side3_in.wheel[i] = wheel2_ff[i];
         work3_in.work[i]  = mwsm_pkg::NUM_W'(mag2_ff[i]) *
                             mwsm_pkg::NUM_W'(cfg.wheel_lim);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         side3_ff <= side3_in;
         work3_ff <= work3_in;
      end
   end

   assign side = side3_ff;
   assign work = work3_ff;

endmodule

[rtl/mwsm_div_stage.sv]
module mwsm_div_stage #(
   parameter int BITS = mwsm_pkg::DIV_BITS_PER_STAGE_DEFAULT
) (
   input  logic               clock,
   input  logic               en,
   input  mwsm_pkg::side_type prev_side,
   input  mwsm_pkg::div_type  prev_work,
   output mwsm_pkg::side_type side,
   output mwsm_pkg::div_type  work
);

   localparam int MW = mwsm_pkg::MAG_W;
   localparam int QW = mwsm_pkg::QUO_W;

   mwsm_pkg::side_type side_ff;
   mwsm_pkg::div_type  work_ff, work_in;

   // BITS restoring steps per lane; remainder stays below the divisor,
   // quotient bits shift in at the bottom of the low half
   always_comb begin
      logic [MW-1:0] rem;
      logic [QW-1:0] low;
      logic [MW:0]   trial;
      for (int i = 0; i < mwsm_pkg::NWHEEL; i++) begin
         rem = prev_work.work[i][mwsm_pkg::NUM_W-1:QW];
         low = prev_work.work[i][QW-1:0];
         for (int s = 0; s < BITS; s++) begin
            trial = {rem, low[QW-1]};
            low   = {low[QW-2:0], 1'b0};
            if (trial >= {1'b0, prev_side.top}) begin
               trial  = trial - {1'b0, prev_side.top};
               low[0] = 1'b1;
            end
            rem = trial[MW-1:0];
         end
         work_in.work[i] = {rem, low};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= prev_side;
         work_ff <= work_in;
      end
   end

   assign side = side_ff;
   assign work = work_ff;

endmodule

[rtl/mecanum_wheel_speed_mixer_top.sv]
// Mecanum wheel mixer: each command beat (vx, vy, omega) is clamped to its
// limit, mixed into four wheel speeds, and if the largest wheel magnitude
// exceeds wheel_limit all four are scaled by wheel_limit/max, truncated toward
// zero, with was_scaled set. One command is taken every cycle unless the
// output is stalled with every stage full; the scaling uses a pipelined long
// division, which retires DIV_BITS_PER_STAGE quotient bits per stage.
// Backpressure stalls only the full part of the pipe, so bubbles are squeezed
// out. Limit registers should be written only with the pipe empty.
module mecanum_wheel_speed_mixer_top #(
   parameter int DIV_BITS_PER_STAGE = mwsm_pkg::DIV_BITS_PER_STAGE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   mwsm_req_if.sink    req_bus,
   mwsm_rsp_if.source  rsp_bus,
   mwsm_csr_if.sink    csr_bus
);

   localparam int NW         = mwsm_pkg::NWHEEL;
   localparam int WW         = mwsm_pkg::WHEEL_W;
   localparam int QW         = mwsm_pkg::QUO_W;
   localparam int DIV_STAGES = QW / DIV_BITS_PER_STAGE;
   localparam int NSTAGE     = mwsm_pkg::MIX_STAGES + DIV_STAGES + 1;

   mwsm_pkg::cfg_type  cfg;
   logic [NSTAGE-1:0]  en;
   logic [NSTAGE-1:0]  valid;

   mwsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   mwsm_pipe_ctrl #(
      .NSTAGE (NSTAGE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .out_ready (rsp_bus.ready),
      .in_ready  (req_bus.ready),
      .en        (en),
      .valid     (valid)
   );

   // Clamp, mix, max and multiply
   mwsm_pkg::side_type side_s [DIV_STAGES+1];
   mwsm_pkg::div_type  work_s [DIV_STAGES+1];

   mwsm_mix u_mix (
      .clock     (clock),
      .en        (en[mwsm_pkg::MIX_STAGES-1:0]),
      .cfg       (cfg),
      .cmd_vx    (req_bus.cmd_vx),
      .cmd_vy    (req_bus.cmd_vy),
      .cmd_omega (req_bus.cmd_omega),
      .side      (side_s[0]),
      .work      (work_s[0])
   );

   // Long division chain
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      mwsm_div_stage #(
         .BITS (DIV_BITS_PER_STAGE)
      ) u_div (
         .clock     (clock),
         .en        (en[mwsm_pkg::MIX_STAGES + k]),
         .prev_side (side_s[k]),
         .prev_work (work_s[k]),
         .side      (side_s[k+1]),
         .work      (work_s[k+1])
      );
   end

   // Output stage: restore sign on the scaled magnitude
   logic [WW-1:0] wheel_ff [NW];
   logic [WW-1:0] wheel_in [NW];
   logic          scaled_ff;
   logic [WW-1:0] quo;

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         quo = {1'b0, work_s[DIV_STAGES].work[i][QW-1:0]};
         if (side_s[DIV_STAGES].scaled) begin
            wheel_in[i] = side_s[DIV_STAGES].wheel[i][WW-1] ? (~quo + 1'b1) : quo;
         end else begin
            wheel_in[i] = side_s[DIV_STAGES].wheel[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NSTAGE-1]) begin
         wheel_ff  <= wheel_in;
         scaled_ff <= side_s[DIV_STAGES].scaled;
      end
   end

   assign rsp_bus.valid         = valid[NSTAGE-1];
   assign rsp_bus.wheel_a_speed = $signed(wheel_ff[0]);
   assign rsp_bus.wheel_b_speed = $signed(wheel_ff[1]);
   assign rsp_bus.wheel_c_speed = $signed(wheel_ff[2]);
   assign rsp_bus.wheel_d_speed = $signed(wheel_ff[3]);
   assign rsp_bus.was_scaled    = scaled_ff;

   // Every delivered wheel stays within the wheel limit
   a_wheel_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         mwsm_pkg::wheel_mag(wheel_ff[0]) <= cfg.wheel_lim &&
         mwsm_pkg::wheel_mag(wheel_ff[1]) <= cfg.wheel_lim &&
         mwsm_pkg::wheel_mag(wheel_ff[2]) <= cfg.wheel_lim &&
         mwsm_pkg::wheel_mag(wheel_ff[3]) <= cfg.wheel_lim)
      else $error("wheel speed above wheel limit");

   // After scaling, the largest wheel lands exactly on the limit
   a_scaled_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.was_scaled |->
         mwsm_pkg::wheel_mag(wheel_ff[0]) == cfg.wheel_lim ||
         mwsm_pkg::wheel_mag(wheel_ff[1]) == cfg.wheel_lim ||
         mwsm_pkg::wheel_mag(wheel_ff[2]) == cfg.wheel_lim ||
         mwsm_pkg::wheel_mag(wheel_ff[3]) == cfg.wheel_lim)
      else $error("scaled set without a wheel at the limit");

endmodule
